// File: design/dlbs_pkg.sv
// ----------------------------------------------------------------------------
// dlbs_pkg
// Shared types and constants for the dual-link bandwidth steering core.
// ----------------------------------------------------------------------------
package dlbs_pkg;

    localparam int COUNTER_BITS_DEF = 48;

    localparam int TIME_W     = 32;
    localparam int PCT_W      = 7;
    localparam int KBPS_W     = 32;
    localparam int MARK_W     = 32;
    localparam int PID_W      = 32;
    localparam int USED_W     = 42;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Item header bits beyond the byte counter: now_sec, three flags, pkt_tag
    localparam int IN_FIXED_W = TIME_W + 3 + PID_W;

    // interval * 125 fits below 2^39
    localparam int DIVISOR_W = TIME_W + 7;
    localparam int PROD_W    = KBPS_W + PCT_W;
    // (used + 1) * 100 fits below 2^50
    localparam int SCALED_W  = USED_W + 8;

    localparam logic [USED_W-1:0] USED_MAX       = '1;
    localparam logic [6:0]        BYTES_PER_KBIT = 7'd125;
    localparam logic [6:0]        PERCENT_SCALE  = 7'd100;

    // Result item layout on m_tdata
    localparam int OUT_PID_LSB   = 0;
    localparam int OUT_MARK_LSB  = OUT_PID_LSB + PID_W;
    localparam int OUT_USED_LSB  = OUT_MARK_LSB + MARK_W;
    localparam int OUT_PREF_BIT  = OUT_USED_LSB + USED_W;
    localparam int OUT_FIELDS_W  = OUT_PREF_BIT + 1;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEER_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_PCT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_PCT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_KBPS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAILOVER_EN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_VALUE  = 3'd5;

    localparam logic [PCT_W-1:0]  UPPER_PCT_RST = 7'd80;
    localparam logic [PCT_W-1:0]  LOWER_PCT_RST = 7'd75;
    localparam logic [KBPS_W-1:0] LINK_KBPS_RST = 32'd1;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_LINK   = 2'd1,
        CMD_PACKET = 2'd2,
        CMD_RELOAD = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_SETUP,
        ST_DIVIDE,
        ST_SAT,
        ST_PRODUCTS,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic ld_item;
        logic exec;
        logic div_setup;
        logic div_step;
        logic div_store;
        logic hist_prod;
        logic compare;
        logic ld_out;
    } dp_cmd_t;

    typedef struct packed {
        logic tick_go;
        logic div_ok;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/dlbs_ctrl.sv
// ----------------------------------------------------------------------------
// dlbs_ctrl
// Sequencer for the steering core: accepts an item, walks the tick path
// through the serial divider and threshold check, and releases the result.
// ----------------------------------------------------------------------------
module dlbs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  dlbs_pkg::dp_status_t  status,
    output dlbs_pkg::dp_cmd_t     cmd
);

    dlbs_pkg::state_t state_reg;
    dlbs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            dlbs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next  = dlbs_pkg::ST_DECODE;
                end
            end
            dlbs_pkg::ST_DECODE:
            begin
                cmd.exec = 1'b1;
                if (!status.tick_go)
                begin
                    state_next = dlbs_pkg::ST_FINISH;
                end
                else if (status.div_ok)
                begin
                    state_next = dlbs_pkg::ST_DIV_SETUP;
                end
                else
                begin
                    state_next = dlbs_pkg::ST_PRODUCTS;
                end
            end
            dlbs_pkg::ST_DIV_SETUP:
            begin
                cmd.div_setup = 1'b1;
                state_next    = dlbs_pkg::ST_DIVIDE;
            end
            dlbs_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = dlbs_pkg::ST_SAT;
                end
            end
            dlbs_pkg::ST_SAT:
            begin
                cmd.div_store = 1'b1;
                state_next    = dlbs_pkg::ST_PRODUCTS;
            end
            dlbs_pkg::ST_PRODUCTS:
            begin
                cmd.hist_prod = 1'b1;
                state_next    = dlbs_pkg::ST_COMPARE;
            end
            dlbs_pkg::ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = dlbs_pkg::ST_FINISH;
            end
            dlbs_pkg::ST_FINISH:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = dlbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dlbs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/dlbs_datapath.sv
// ----------------------------------------------------------------------------
// dlbs_datapath
// Configuration registers, link and rate state, serial divider for the rate
// measurement, threshold compare and the result register.
// ----------------------------------------------------------------------------
module dlbs_datapath #(
    parameter int COUNTER_BITS = dlbs_pkg::COUNTER_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wen,
    input  logic [dlbs_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [dlbs_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic [1:0]                               s_tuser,
    input  logic [((COUNTER_BITS + dlbs_pkg::IN_FIXED_W + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                                     m_tready,
    output logic                                     m_tvalid,
    output logic [0:0]                               m_tuser,
    output logic [dlbs_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  dlbs_pkg::dp_cmd_t                        cmd,
    output dlbs_pkg::dp_status_t                     status
);

    localparam int OFS_NOW    = COUNTER_BITS;
    localparam int OFS_PUP    = OFS_NOW + dlbs_pkg::TIME_W;
    localparam int OFS_SUP    = OFS_PUP + 1;
    localparam int OFS_CLR    = OFS_SUP + 1;
    localparam int OFS_PID    = OFS_CLR + 1;
    localparam int CNT_W      = $clog2(COUNTER_BITS);
    localparam int QW         = (COUNTER_BITS > dlbs_pkg::USED_W) ?
                                COUNTER_BITS : dlbs_pkg::USED_W;

    // configuration
    logic                         steer_en_reg;
    logic [dlbs_pkg::PCT_W-1:0]   upper_reg;
    logic [dlbs_pkg::PCT_W-1:0]   lower_reg;
    logic [dlbs_pkg::KBPS_W-1:0]  link_kbps_reg;
    logic                         failover_en_reg;
    logic [dlbs_pkg::MARK_W-1:0]  mark_reg;

    // latched item
    dlbs_pkg::cmd_t               item_cmd_reg;
    logic [COUNTER_BITS-1:0]      bytes_reg;
    logic [dlbs_pkg::TIME_W-1:0]  now_reg;
    logic                         pup_reg;
    logic                         sup_reg;
    logic                         clr_reg;
    logic [dlbs_pkg::PID_W-1:0]   pid_reg;

    // steering state
    logic                         primary_up_reg;
    logic                         secondary_up_reg;
    logic                         prefer_reg;
    logic                         reload_reg;
    logic [COUNTER_BITS-1:0]      last_bytes_reg;
    logic [dlbs_pkg::TIME_W-1:0]  last_sec_reg;
    logic [dlbs_pkg::USED_W-1:0]  used_reg;

    // divider and compare operands
    logic [dlbs_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [dlbs_pkg::DIVISOR_W-1:0] rem_reg;
    logic [COUNTER_BITS-1:0]        quo_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [dlbs_pkg::PROD_W-1:0]    prod_hi_reg;
    logic [dlbs_pkg::PROD_W-1:0]    prod_lo_reg;
    logic [dlbs_pkg::SCALED_W-1:0]  u100_reg;
    logic [dlbs_pkg::SCALED_W-1:0]  u100p_reg;

    // result register
    logic                           m_tvalid_reg;
    logic [dlbs_pkg::PID_W-1:0]     pid_out_reg;
    logic                           applied_reg;
    logic [dlbs_pkg::MARK_W-1:0]    vmark_reg;
    logic [dlbs_pkg::USED_W-1:0]    used_out_reg;
    logic                           pref_out_reg;

    logic [dlbs_pkg::TIME_W-1:0]    interval;
    logic [dlbs_pkg::DIVISOR_W:0]   trial;
    logic                           trial_ge;
    logic [QW-1:0]                  quo_ext;
    logic [dlbs_pkg::USED_W-1:0]    used_sat;
    logic                           fo_primary;
    logic                           fo_secondary;
    logic                           fo_prefer;
    logic                           gt_hi;
    logic                           lt_hi;
    logic                           lt_lo;
    logic                           applied;

    always_comb
    begin
        interval = now_reg - last_sec_reg;
        trial    = {rem_reg, quo_reg[COUNTER_BITS-1]};
        trial_ge = (trial >= {1'b0, divisor_reg});
        quo_ext  = QW'(quo_reg);
        used_sat = (quo_ext > QW'(dlbs_pkg::USED_MAX)) ? dlbs_pkg::USED_MAX :
                   quo_ext[dlbs_pkg::USED_W-1:0];

        // a link update uses the new link bits, a reload the stored ones
        fo_primary   = (item_cmd_reg == dlbs_pkg::CMD_LINK) ? pup_reg : primary_up_reg;
        fo_secondary = (item_cmd_reg == dlbs_pkg::CMD_LINK) ? sup_reg : secondary_up_reg;
        fo_prefer    = !fo_primary && fo_secondary && failover_en_reg;

        // used > floor(P/100)  <=>  P < 100*used
        // used < floor(P/100)  <=>  100*(used+1) <= P
        gt_hi = (dlbs_pkg::SCALED_W'(prod_hi_reg) < u100_reg);
        lt_hi = (u100p_reg <= dlbs_pkg::SCALED_W'(prod_hi_reg));
        lt_lo = (u100p_reg <= dlbs_pkg::SCALED_W'(prod_lo_reg));

        applied = (item_cmd_reg == dlbs_pkg::CMD_PACKET) && steer_en_reg && prefer_reg;

        status.tick_go  = (item_cmd_reg == dlbs_pkg::CMD_TICK) &&
                          primary_up_reg && secondary_up_reg;
        status.div_ok   = (last_sec_reg != '0) && (last_bytes_reg != '0) &&
                          (bytes_reg >= last_bytes_reg) && (interval != '0);
        status.div_last = (cnt_reg == CNT_W'(COUNTER_BITS - 1));
        status.out_free = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_en_reg    <= 1'b0;
            upper_reg       <= dlbs_pkg::UPPER_PCT_RST;
            lower_reg       <= dlbs_pkg::LOWER_PCT_RST;
            link_kbps_reg   <= dlbs_pkg::LINK_KBPS_RST;
            failover_en_reg <= 1'b1;
            mark_reg        <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                dlbs_pkg::REG_STEER_EN:    steer_en_reg    <= cfg_data[0];
                dlbs_pkg::REG_UPPER_PCT:   upper_reg       <= cfg_data[dlbs_pkg::PCT_W-1:0];
                dlbs_pkg::REG_LOWER_PCT:   lower_reg       <= cfg_data[dlbs_pkg::PCT_W-1:0];
                dlbs_pkg::REG_LINK_KBPS:   link_kbps_reg   <= cfg_data[dlbs_pkg::KBPS_W-1:0];
                dlbs_pkg::REG_FAILOVER_EN: failover_en_reg <= cfg_data[0];
                dlbs_pkg::REG_MARK_VALUE:  mark_reg        <= cfg_data[dlbs_pkg::MARK_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            item_cmd_reg <= dlbs_pkg::cmd_t'(s_tuser);
            bytes_reg    <= s_tdata[COUNTER_BITS-1:0];
            now_reg      <= s_tdata[OFS_NOW +: dlbs_pkg::TIME_W];
            pup_reg      <= s_tdata[OFS_PUP];
            sup_reg      <= s_tdata[OFS_SUP];
            clr_reg      <= s_tdata[OFS_CLR];
            pid_reg      <= s_tdata[OFS_PID +: dlbs_pkg::PID_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_up_reg   <= 1'b0;
            secondary_up_reg <= 1'b0;
            prefer_reg       <= 1'b0;
            reload_reg       <= 1'b0;
            last_bytes_reg   <= '0;
            last_sec_reg     <= '0;
            used_reg         <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (item_cmd_reg)
                    dlbs_pkg::CMD_LINK:
                    begin
                        primary_up_reg   <= pup_reg;
                        secondary_up_reg <= sup_reg;
                        prefer_reg       <= fo_prefer;
                    end
                    dlbs_pkg::CMD_RELOAD:
                    begin
                        reload_reg <= 1'b1;
                        prefer_reg <= fo_prefer;
                        if (clr_reg)
                        begin
                            last_bytes_reg <= '0;
                            last_sec_reg   <= '0;
                            used_reg       <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.div_store)
            begin
                used_reg <= used_sat;
            end
            if (cmd.hist_prod)
            begin
                last_bytes_reg <= bytes_reg;
                last_sec_reg   <= now_reg;
            end
            if (cmd.compare)
            begin
                if (prefer_reg)
                begin
                    if (lt_lo || (reload_reg && lt_hi))
                    begin
                        prefer_reg <= 1'b0;
                    end
                end
                else if (gt_hi)
                begin
                    prefer_reg <= 1'b1;
                end
                reload_reg <= 1'b0;
            end
        end
    end

    // restoring divider: (bytes delta) / (125 * interval), one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_setup)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_setup)
        begin
            divisor_reg <= dlbs_pkg::DIVISOR_W'(interval) *
                           dlbs_pkg::DIVISOR_W'(dlbs_pkg::BYTES_PER_KBIT);
            quo_reg     <= bytes_reg - last_bytes_reg;
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= dlbs_pkg::DIVISOR_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[dlbs_pkg::DIVISOR_W-1:0];
            end
            quo_reg <= {quo_reg[COUNTER_BITS-2:0], trial_ge};
        end
        if (cmd.hist_prod)
        begin
            prod_hi_reg <= dlbs_pkg::PROD_W'(link_kbps_reg) * dlbs_pkg::PROD_W'(upper_reg);
            prod_lo_reg <= dlbs_pkg::PROD_W'(link_kbps_reg) * dlbs_pkg::PROD_W'(lower_reg);
            u100_reg    <= dlbs_pkg::SCALED_W'(used_reg) *
                           dlbs_pkg::SCALED_W'(dlbs_pkg::PERCENT_SCALE);
            u100p_reg   <= dlbs_pkg::SCALED_W'(used_reg) *
                           dlbs_pkg::SCALED_W'(dlbs_pkg::PERCENT_SCALE) +
                           dlbs_pkg::SCALED_W'(dlbs_pkg::PERCENT_SCALE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.ld_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            pid_out_reg  <= (item_cmd_reg == dlbs_pkg::CMD_PACKET) ? pid_reg : '0;
            applied_reg  <= applied;
            vmark_reg    <= applied ? mark_reg : '0;
            used_out_reg <= used_reg;
            pref_out_reg <= prefer_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = applied_reg;
    assign m_tdata    = {{dlbs_pkg::OUT_PAD_W{1'b0}}, pref_out_reg, used_out_reg,
                         vmark_reg, pid_out_reg};

endmodule

// File: design/dual_link_bandwidth_steering_core.sv
// ----------------------------------------------------------------------------
// dual_link_bandwidth_steering_core
// Steers traffic between a primary and a secondary link from measured rate.
// ----------------------------------------------------------------------------
// Usage:
//   Input items enter on s_tvalid/s_tready; s_tuser carries the command
//   (tick, link status, packet, config reload), s_tdata the operands.
//   Every item gives exactly one result item on m_tvalid/m_tready.
//   Registers are to be written through cfg_wen/cfg_index/cfg_data while
//   idle; the user must keep to this, the block itself does not enforce it.
// Sequencing:
//   Link status, packet and reload items go from decode straight to the
//   result step. Tick with both links up: the rate comes from a restoring
//   divider that resolves one quotient bit per cycle, followed by the
//   threshold compare; a tick without usable history skips the divider.
//   One item is in work at a time; s_tready is high only when idle.
// Reset:
//   rst_n clears the link state, steering flag, rate history and the output
//   valid, and loads the register defaults.
// Stall:
//   A held result stays in the output register; the next item is accepted
//   and worked, then waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module dual_link_bandwidth_steering_core #(
    parameter int COUNTER_BITS = dlbs_pkg::COUNTER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wen,
    input  logic [dlbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dlbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tuser: cmd[1:0]
    input  logic [1:0]                        s_tuser,
    // s_tdata: byte_count, now_sec, primary_link_up, secondary_link_up,
    //          clear_rate, pkt_tag, zero fill
    input  logic [((COUNTER_BITS + dlbs_pkg::IN_FIXED_W + 7) / 8) * 8 - 1:0] s_tdata,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tuser: mark_applied
    output logic [0:0]                        m_tuser,
    // m_tdata: pkt_tag_out, verdict_mark, used_kbps_out,
    //          prefer_secondary_out, zero fill
    output logic [dlbs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    dlbs_pkg::dp_cmd_t    dp_cmd;
    dlbs_pkg::dp_status_t dp_status;

    dlbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    dlbs_datapath #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

endmodule

// File: design/dlbs_checker.sv
// ----------------------------------------------------------------------------
// dlbs_checker
// Port-level assertions for the steering core, bound to the top level.
// ----------------------------------------------------------------------------
module dlbs_checker #(
    parameter int COUNTER_BITS = dlbs_pkg::COUNTER_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [0:0]                        m_tuser,
    input logic [dlbs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while busy");

    // unmarked verdict carries no mark
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |->
            m_tdata[dlbs_pkg::OUT_MARK_LSB +: dlbs_pkg::MARK_W] == '0)
    else $error("mark present on unmarked verdict");

    // a marked verdict implies the secondary link is preferred
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[dlbs_pkg::OUT_PREF_BIT])
    else $error("marked verdict without secondary preference");

endmodule

bind dual_link_bandwidth_steering_core dlbs_checker #(
    .COUNTER_BITS (COUNTER_BITS)
) u_dlbs_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

// File: bench/dual_link_bandwidth_steering_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_link_bandwidth_steering_core_test
// Drives tick, link status, packet and reload items into the steering core
// under random idling and back-pressure. Each result item is checked against
// a rate and hysteresis predictor kept in the bench.
// ----------------------------------------------------------------------------
module dual_link_bandwidth_steering_core_test;

    import dlbs_pkg::*;

    localparam int CNT_W      = COUNTER_BITS_DEF;
    localparam int IN_W       = ((CNT_W + IN_FIXED_W + 7) / 8) * 8;
    localparam int DRAIN_CYC  = 8;
    localparam int SETTLE_CYC = CNT_W + 12;
    localparam longint unsigned TIMEOUT_NS = 64'd12_000_000;

    // Indexes outside the register map; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        cmd_t              cmd;
        logic [CNT_W-1:0]  bytes;
        logic [TIME_W-1:0] secs;
        logic              pri_up;
        logic              sec_up;
        logic              clear_rate;
        logic [PID_W-1:0]  pid;
    } steer_item_t;

    typedef struct {
        logic [PID_W-1:0]  pid;
        logic              applied;
        logic [MARK_W-1:0] mark;
        logic [USED_W-1:0] used;
        logic              prefer;
    } verdict_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    // s_tuser: cmd[1:0]
    logic [1:0]             s_tuser;
    // s_tdata: byte_count, now_sec, primary_link_up, secondary_link_up,
    //          clear_rate, pkt_tag, zero fill
    logic [IN_W-1:0]        s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // m_tuser: mark_applied
    logic [0:0]             m_tuser;
    // m_tdata: pkt_tag_out, verdict_mark, used_kbps_out,
    //          prefer_secondary_out, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;

    dual_link_bandwidth_steering_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // Register copies
    logic              cf_steer    = 1'b0;
    logic [PCT_W-1:0]  cf_upper    = UPPER_PCT_RST;
    logic [PCT_W-1:0]  cf_lower    = LOWER_PCT_RST;
    logic [KBPS_W-1:0] cf_link     = LINK_KBPS_RST;
    logic              cf_failover = 1'b1;
    logic [MARK_W-1:0] cf_mark     = '0;

    // Steering state
    logic              lk_primary    = 1'b0;
    logic              lk_secondary  = 1'b0;
    logic              use_secondary = 1'b0;
    logic              relax_release = 1'b0;
    logic [CNT_W-1:0]  hist_bytes    = '0;
    logic [TIME_W-1:0] hist_secs     = '0;
    logic [USED_W-1:0] rate_kbps     = '0;

    verdict_t verdict_q[$];
    int       fail_count    = 0;
    int       shown_count   = 0;
    bit       tx_idle_on    = 1'b1;
    bit       rx_idle_on    = 1'b1;
    int       rx_hold_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("dual_link_bandwidth_steering_core_test: FAIL");
        $finish;
    end

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_STEER_EN:    cf_steer    = val[0];
            REG_UPPER_PCT:   cf_upper    = val[PCT_W-1:0];
            REG_LOWER_PCT:   cf_lower    = val[PCT_W-1:0];
            REG_LINK_KBPS:   cf_link     = val[KBPS_W-1:0];
            REG_FAILOVER_EN: cf_failover = val[0];
            REG_MARK_VALUE:  cf_mark     = val[MARK_W-1:0];
            default:         ;
        endcase
    endfunction

    function automatic verdict_t steer_predict(steer_item_t it);
        verdict_t          v;
        logic [TIME_W-1:0] gap_s;
        longint unsigned   delta;
        longint unsigned   kbps;
        longint unsigned   hi;
        longint unsigned   lo;
        v.pid     = '0;
        v.applied = 1'b0;
        v.mark    = '0;
        case (it.cmd)
            CMD_TICK:
            begin
                if (lk_primary && lk_secondary)
                begin
                    gap_s = it.secs - hist_secs;
                    if (hist_secs != 0 && hist_bytes != 0 && it.bytes >= hist_bytes
                        && gap_s != 0)
                    begin
                        // bytes * 8 / 1000 is exactly bytes / 125
                        delta = 64'(it.bytes - hist_bytes);
                        kbps  = (delta / 125) / gap_s;
                        rate_kbps = (kbps > 64'(USED_MAX)) ? USED_MAX : kbps[USED_W-1:0];
                    end
                    hist_bytes = it.bytes;
                    hist_secs  = it.secs;
                    hi = (64'(cf_link) * 64'(cf_upper)) / 100;
                    lo = (64'(cf_link) * 64'(cf_lower)) / 100;
                    if (use_secondary)
                    begin
                        if (64'(rate_kbps) < lo || (relax_release && 64'(rate_kbps) < hi))
                            use_secondary = 1'b0;
                    end
                    else if (64'(rate_kbps) > hi)
                        use_secondary = 1'b1;
                    relax_release = 1'b0;
                end
            end
            CMD_LINK:
            begin
                lk_primary    = it.pri_up;
                lk_secondary  = it.sec_up;
                use_secondary = !lk_primary && lk_secondary && cf_failover;
            end
            CMD_PACKET:
            begin
                v.pid = it.pid;
                if (cf_steer && use_secondary)
                begin
                    v.applied = 1'b1;
                    v.mark    = cf_mark;
                end
            end
            default:
            begin
                relax_release = 1'b1;
                if (it.clear_rate)
                begin
                    hist_bytes = '0;
                    hist_secs  = '0;
                    rate_kbps  = '0;
                end
                use_secondary = !lk_primary && lk_secondary && cf_failover;
            end
        endcase
        v.used   = rate_kbps;
        v.prefer = use_secondary;
        return v;
    endfunction

    // Unused fields carry random junk that the block must ignore
    function automatic steer_item_t any_item();
        steer_item_t it;
        it.cmd        = cmd_t'($urandom_range(0, 3));
        it.bytes      = CNT_W'({$urandom(), $urandom()});
        it.secs       = $urandom();
        it.pri_up     = 1'($urandom_range(0, 1));
        it.sec_up     = 1'($urandom_range(0, 1));
        it.clear_rate = 1'($urandom_range(0, 1));
        it.pid        = $urandom();
        return it;
    endfunction

    function automatic steer_item_t make_tick(logic [CNT_W-1:0] b, logic [TIME_W-1:0] s);
        steer_item_t it;
        it       = any_item();
        it.cmd   = CMD_TICK;
        it.bytes = b;
        it.secs  = s;
        return it;
    endfunction

    function automatic steer_item_t make_link(logic p, logic s);
        steer_item_t it;
        it        = any_item();
        it.cmd    = CMD_LINK;
        it.pri_up = p;
        it.sec_up = s;
        return it;
    endfunction

    function automatic steer_item_t make_packet(logic [PID_W-1:0] id);
        steer_item_t it;
        it     = any_item();
        it.cmd = CMD_PACKET;
        it.pid = id;
        return it;
    endfunction

    function automatic steer_item_t make_reload(logic clr);
        steer_item_t it;
        it            = any_item();
        it.cmd        = CMD_RELOAD;
        it.clear_rate = clr;
        return it;
    endfunction

    task automatic send_item(steer_item_t it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {{(IN_W - CNT_W - IN_FIXED_W){1'b0}}, it.pid, it.clear_rate,
                     it.sec_up, it.pri_up, it.secs, it.bytes};
        do
            @(posedge clk);
        while (!s_tready);
        verdict_q.push_back(steer_predict(it));
    endtask

    // Hold the input until every outstanding result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic program_regs(logic steer, logic [PCT_W-1:0] up, logic [PCT_W-1:0] lo,
                                logic [KBPS_W-1:0] kbps, logic fo, logic [MARK_W-1:0] mark);
        logic [CFG_IDX_W-1:0]  idx [7];
        logic [CFG_DATA_W-1:0] val [7];
        int i;
        wait_drain();
        // Junk in the upper bits of narrow registers must be dropped
        idx = '{REG_STEER_EN, REG_UPPER_PCT, REG_LOWER_PCT, REG_LINK_KBPS,
                REG_FAILOVER_EN, REG_MARK_VALUE,
                ($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B)};
        val = '{($urandom() & 32'hFFFF_FFFE) | 32'(steer),
                ($urandom() & 32'hFFFF_FF80) | 32'(up),
                ($urandom() & 32'hFFFF_FF80) | 32'(lo),
                kbps,
                ($urandom() & 32'hFFFF_FFFE) | 32'(fo),
                mark,
                $urandom()};
        for (i = 0; i < 7; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            apply_reg(idx[i], val[i]);
        end
        cfg_wen <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_item(make_packet(32'hFFFF_FFFF));
        send_item(make_tick(48'd5000, 32'd20));
        send_item(make_link(1'b0, 1'b1));
        send_item(make_reload(1'b0));
        send_item(make_link(1'b1, 1'b1));
    endtask

    task automatic test_rate_hysteresis();
        logic [CNT_W-1:0] b;
        program_regs(1'b1, 7'd80, 7'd75, 32'd10000, 1'b1, 32'hFFFF_FFFF);
        send_item(make_link(1'b1, 1'b1));
        b = 48'd1000;
        send_item(make_tick(b, 32'd10));
        b += 48'(8001 * 125);
        send_item(make_tick(b, 32'd11));
        send_item(make_packet(32'h0000_0000));
        b += 48'(7600 * 250);
        send_item(make_tick(b, 32'd13));
        b += 48'(7499 * 125);
        send_item(make_tick(b, 32'd14));
        b += 48'(8500 * 125 + 124);
        send_item(make_tick(b, 32'd15));
        // after a reload, falling below the upper threshold releases
        send_item(make_reload(1'b0));
        b += 48'(7800 * 125);
        send_item(make_tick(b, 32'd16));
        b += 48'd123456;
        send_item(make_tick(b, 32'd16));
        send_item(make_tick(b - 48'd10, 32'd17));
        send_item(make_reload(1'b1));
        send_item(make_tick(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        // time wraps past zero
        send_item(make_tick(48'hFFFF_FFFF_FFFF, 32'd5));
    endtask

    task automatic test_register_extremes();
        program_regs(1'b0, 7'd0, 7'd0, 32'd0, 1'b0, 32'd0);
        send_item(make_link(1'b0, 1'b1));
        send_item(make_link(1'b1, 1'b1));
        send_item(make_tick(48'd100, 32'd1));
        send_item(make_tick(48'd475, 32'd2));
        send_item(make_packet($urandom()));
        program_regs(1'b1, 7'd127, 7'd100, 32'hFFFF_FFFF, 1'b1, 32'h8000_0001);
        send_item(make_packet($urandom()));
        send_item(make_reload(1'b1));
    endtask

    task automatic test_backpressure();
        int i;
        wait_drain();
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = 400;
        for (i = 0; i < 14; i++)
        begin
            if (i % 5 == 2)
                send_item(make_tick(48'd1000 + 48'(i * 250000), 32'd40 + 32'(i)));
            else
                send_item(make_packet($urandom()));
        end
        wait_drain();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int               phase;
        int               n;
        int               pick;
        int               itv;
        longint unsigned  hi;
        longint unsigned  lo;
        longint unsigned  target;
        longint unsigned  delta;
        logic [CNT_W-1:0] b_now;
        logic [TIME_W-1:0] s_now;
        b_now = 48'd5000;
        s_now = 32'd100;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: program_regs(1'b1, 7'd127, 7'd0, 32'hFFFF_FFFF, 1'b1, $urandom());
                1: program_regs(1'b1, 7'd0, 7'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
                2: program_regs(1'b0, 7'd100, 7'd100, 32'd1, 1'b1, 32'd0);
                default:
                    program_regs(1'($urandom_range(0, 1)),
                                 7'(($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                                                : $urandom_range(1, 100)),
                                 7'(($urandom_range(0, 9) == 0) ? $urandom_range(101, 127)
                                                                : $urandom_range(1, 100)),
                                 32'($urandom_range(1, 200000)),
                                 1'($urandom_range(0, 1)),
                                 $urandom());
            endcase
            tx_idle_on = (phase % 3) != 1;
            rx_idle_on = (phase % 4) != 2;
            hi = (64'(cf_link) * 64'(cf_upper)) / 100;
            lo = (64'(cf_link) * 64'(cf_lower)) / 100;
            send_item(make_link(1'b1, 1'b1));
            for (n = 0; n < 150; n++)
            begin
                if (n % 50 == 49)
                    wait_drain();
                pick = $urandom_range(0, 99);
                if (pick < 58)
                begin
                    itv = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
                    // aim the rate at the thresholds most of the time
                    case ($urandom_range(0, 7))
                        0:       target = hi;
                        1:       target = hi + 1;
                        2:       target = (hi > 0) ? hi - 1 : 0;
                        3:       target = lo;
                        4:       target = (lo > 0) ? lo - 1 : 0;
                        5:       target = lo + 1;
                        default: target = {$urandom(), $urandom()} % (2 * hi + 3);
                    endcase
                    delta = target * itv * 125 + $urandom_range(0, 124);
                    if ($urandom_range(0, 29) == 0 && b_now > 48'd2000)
                        b_now -= 48'($urandom_range(1, 2000));
                    else if (64'(b_now) + delta > 64'h0000_FFFF_FFFF_FFFF)
                    begin
                        // counter about to overflow: restart the history
                        send_item(make_reload(1'b1));
                        b_now = 48'($urandom_range(1, 1000));
                        continue;
                    end
                    else
                        b_now += delta[CNT_W-1:0];
                    s_now += itv;
                    send_item(make_tick(b_now, s_now));
                end
                else if (pick < 72)
                    send_item(make_packet($urandom()));
                else if (pick < 80)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(make_link(1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1))));
                    else
                        send_item(make_link(1'b1, 1'b1));
                end
                else if (pick < 87)
                    send_item(make_reload($urandom_range(0, 3) == 0));
                else
                    send_item(any_item());
            end
        end
    endtask

    // Result side: stall per item, plus an occasional long hold-off
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = (rx_idle_on ? $urandom_range(0, 14) : 0) + rx_hold_cycles;
            rx_hold_cycles = 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        verdict_t want;
        logic [PID_W-1:0]  got_pid;
        logic [MARK_W-1:0] got_mark;
        logic [USED_W-1:0] got_used;
        logic              got_pref;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_pid  = m_tdata[OUT_PID_LSB +: PID_W];
            got_mark = m_tdata[OUT_MARK_LSB +: MARK_W];
            got_used = m_tdata[OUT_USED_LSB +: USED_W];
            got_pref = m_tdata[OUT_PREF_BIT];
            if (verdict_q.size() == 0)
            begin
                fail_count++;
                if (shown_count < 10)
                begin
                    shown_count++;
                    $display("unexpected result item: pid %h applied %b mark %h used %0d pref %b",
                             got_pid, m_tuser[0], got_mark, got_used, got_pref);
                end
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got_pid !== want.pid || m_tuser[0] !== want.applied
                    || got_mark !== want.mark || got_used !== want.used
                    || got_pref !== want.prefer)
                begin
                    fail_count++;
                    if (shown_count < 10)
                    begin
                        shown_count++;
                        $display("mismatch: exp pid %h applied %b mark %h used %0d pref %b",
                                 want.pid, want.applied, want.mark, want.used, want.prefer);
                        $display("          got pid %h applied %b mark %h used %0d pref %b",
                                 got_pid, m_tuser[0], got_mark, got_used, got_pref);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_TICK;
        s_tdata   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_rate_hysteresis();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_count == 0 && verdict_q.size() == 0)
            $display("dual_link_bandwidth_steering_core_test: PASS");
        else
            $display("dual_link_bandwidth_steering_core_test: FAIL");
        $finish;
    end

endmodule
